/* design/controller_input_smoother_defines.svh */
// Assertion macros used by the state machine of the controller input smoother.
`ifndef CONTROLLER_INPUT_SMOOTHER_DEFINES_SVH
`define CONTROLLER_INPUT_SMOOTHER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only once reset has been released.
`define CSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSM_ASSERT(lbl, prop, msg)
`define CSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/csm_pkg.sv */
// Package with the types and constants of the controller input smoother.
package csm_pkg;

  // Q1.14 unity.
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  // Channel layout of one hand: four analogue channels, then the buttons.
  localparam int ANALOG_PER_HAND = 4;
  localparam int SHOWN_BUTTONS   = 7;
  localparam int RES_COUNT       = ANALOG_PER_HAND + SHOWN_BUTTONS;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_HAND_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd2;

  // alpha = floor(p * 2^14 / 10^6) = floor(p * 256 / 15625) for p below 10^6,
  // done as (p * RECIP_M) >> RECIP_SHIFT; exact for every p below 2^20.
  localparam logic [28:0] RECIP_M     = 29'd281474977;
  localparam int          RECIP_SHIFT = 34;
  localparam logic [29:0] ALPHA_SAT   = 30'd1000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic alpha1;      // elapsed time times rate
    logic alpha2;      // scale to Q1.14 and saturate
    logic rd_en;       // read one level of the item's hand
    logic out_load;    // move the finished result to the output register
    logic out_accept;  // the result is for an accepted item
  } csm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hand_ok;     // hand in range and present
  } csm_status_t;

endpackage

/* design/csm_ctrl.sv */
// Controller state machine of the controller input smoother.
`include "controller_input_smoother_defines.svh"
module csm_ctrl #(
  parameter int CH  = 11,
  parameter int CHW = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  csm_pkg::csm_status_t  status,
  output csm_pkg::csm_cmd_t     cmd,
  output logic [CHW-1:0]        rd_ch
);
  import csm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ALPHA1 = 3'd1;
  localparam logic [2:0] ST_ALPHA2 = 3'd2;
  localparam logic [2:0] ST_SMOOTH = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [CHW-1:0] CH_LAST = CHW'(CH - 1);

  logic [2:0]     state_r, state_nxt;
  logic [CHW-1:0] ch_r, ch_nxt;
  logic           acc_r, acc_nxt;
  logic           out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    acc_nxt    = acc_r;
    cmd        = '0;
    in_ready   = (state_r == ST_IDLE);
    cmd.load   = in_valid && (state_r == ST_IDLE);
    cmd.out_accept = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ALPHA1;
        end
      end
      ST_ALPHA1: begin
        cmd.alpha1 = 1'b1;
        acc_nxt    = status.hand_ok;
        state_nxt  = status.hand_ok ? ST_ALPHA2 : ST_DONE;
      end
      ST_ALPHA2: begin
        cmd.alpha2 = 1'b1;
        ch_nxt     = '0;
        state_nxt  = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd.rd_en = 1'b1;
        if (ch_r == CH_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rd_ch     = ch_r;

  `CSM_ASSERT(a_accept_starts_item, in_valid && in_ready |=> state_r == ST_ALPHA1, "accepted item did not start")
  `CSM_ASSERT(a_ch_in_range, state_r == ST_SMOOTH |-> ch_r <= CH_LAST, "channel counter out of range")
  `CSM_ASSERT(a_no_overwrite, cmd.out_load |-> !out_valid_r || out_ready, "pending result overwritten")
  `CSM_ASSERT(a_valid_from_load, $rose(out_valid_r) |-> $past(cmd.out_load), "result shown without load")

endmodule

/* design/csm_dp.sv */
// Datapath of the controller input smoother: configuration, alpha, level memory.
module csm_dp #(
  parameter int HAND_COUNT = 2,
  parameter int CH         = 11,
  parameter int CHW        = 4,
  parameter int HW         = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [csm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                            in_hand,
  input  logic [19:0]                           in_elapsed_us,
  input  logic signed [15:0]                    in_trigger_in,
  input  logic signed [15:0]                    in_grip_in,
  input  logic signed [15:0]                    in_stick_x_in,
  input  logic signed [15:0]                    in_stick_y_in,
  input  logic [6:0]                            in_buttons_in,
  input  csm_pkg::csm_cmd_t                     cmd,
  input  logic [CHW-1:0]                        rd_ch,
  output csm_pkg::csm_status_t                  status,
  output logic                                  out_accepted,
  output logic [14:0]                           out_trigger_level,
  output logic [14:0]                           out_grip_level,
  output logic signed [15:0]                    out_stick_x_level,
  output logic signed [15:0]                    out_stick_y_level,
  output logic [14:0]                           out_button_level_0,
  output logic [14:0]                           out_button_level_1,
  output logic [14:0]                           out_button_level_2,
  output logic [14:0]                           out_button_level_3,
  output logic [14:0]                           out_button_level_4,
  output logic [14:0]                           out_button_level_5,
  output logic [14:0]                           out_button_level_6
);
  import csm_pkg::*;

  localparam int              HSLOTS    = 2 ** HW;
  localparam int              MEM_DEPTH = 2 ** (HW + CHW);
  localparam logic [2:0]      HC3       = 3'(HAND_COUNT);
  localparam logic [CHW-1:0]  RES_LIMIT = CHW'(RES_COUNT);
  localparam logic [CHW-1:0]  AN_LIMIT  = CHW'(ANALOG_PER_HAND);
  localparam logic [CHW-1:0]  BTN_LIMIT = CHW'(SHOWN_BUTTONS);

  function automatic logic signed [15:0] clamp_unit(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v < 16'sd0) r = 16'sd0;
    else if (v > 16'sd16384) r = 16'sd16384;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v < -16'sd16384) r = -16'sd16384;
    else if (v > 16'sd16384) r = 16'sd16384;
    return r;
  endfunction

  // Configuration registers and per-hand started flags.
  logic [1:0]        present_r;
  logic [9:0]        rate_r;
  logic [19:0]       max_step_r;
  logic [HSLOTS-1:0] started_r;

  // Item registers.
  logic [1:0]         hand_r;
  logic [19:0]        elapsed_r;
  logic signed [15:0] tgt_r [ANALOG_PER_HAND];
  logic [6:0]         buttons_r;
  logic               started_item_r;
  logic [29:0]        p_r;
  logic [14:0]        alpha_r;

  // Level memory pipeline.
  logic signed [15:0] level_mem [MEM_DEPTH];
  logic signed [15:0] rd_data_r;
  logic               wr_en_r;
  logic [CHW-1:0]     wr_ch_r;
  logic signed [15:0] res_r [RES_COUNT];

  logic [HW-1:0]      hidx;
  logic               hand_ok;
  logic [19:0]        dt;
  logic [19:0]        mul_a;
  logic [28:0]        mul_b;
  logic [48:0]        mul_p;
  logic [14:0]        alpha_nxt;

  logic signed [15:0] lvl;
  logic signed [15:0] tgt;
  logic [CHW-1:0]     btn;
  logic signed [16:0] diff;
  logic signed [32:0] smooth_prod;
  logic signed [16:0] new_sum;
  logic signed [15:0] new_level;

  assign hidx    = hand_r[HW-1:0];
  assign hand_ok = ({1'b0, hand_r} < HC3) && (hand_r < 2'd2) && present_r[hand_r[0]];
  assign status.hand_ok = hand_ok;

  // Alpha: one multiplier used twice, first for dt * rate, then for the
  // reciprocal scaling of that product.
  assign dt    = (elapsed_r < max_step_r) ? elapsed_r : max_step_r;
  assign mul_a = cmd.alpha2 ? p_r[19:0] : dt;
  assign mul_b = cmd.alpha2 ? RECIP_M : {19'd0, rate_r};
  assign mul_p = 49'(mul_a) * 49'(mul_b);

  always_comb begin
    if (!started_item_r || (p_r >= ALPHA_SAT)) begin
      alpha_nxt = ONE_Q14;
    end else begin
      alpha_nxt = {1'b0, mul_p[RECIP_SHIFT+13:RECIP_SHIFT]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      rate_r     <= 10'd24;
      max_step_r <= 20'd50000;
      started_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HAND_PRESENT: begin
            for (int h = 0; h < 2; h++) begin
              if (h < HAND_COUNT && (cfg_data[h] != present_r[h])) begin
                started_r[h] <= 1'b0;
              end
            end
            present_r <= cfg_data[1:0];
          end
          CFG_RATE:     rate_r     <= cfg_data[9:0];
          CFG_MAX_STEP: max_step_r <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (cmd.alpha2) begin
        started_r[hidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hand_r    <= in_hand;
      elapsed_r <= in_elapsed_us;
      tgt_r[0]  <= clamp_unit(in_trigger_in);
      tgt_r[1]  <= clamp_unit(in_grip_in);
      tgt_r[2]  <= clamp_sym(in_stick_x_in);
      tgt_r[3]  <= clamp_sym(in_stick_y_in);
      buttons_r <= in_buttons_in;
    end
    if (cmd.alpha1) begin
      p_r            <= mul_p[29:0];
      started_item_r <= started_r[hidx];
    end
    if (cmd.alpha2) begin
      alpha_r <= alpha_nxt;
    end
  end

  // Smoothing step for the channel read in the previous cycle.
  assign btn = wr_ch_r - AN_LIMIT;
  always_comb begin
    if (wr_ch_r < AN_LIMIT) begin
      tgt = tgt_r[wr_ch_r[1:0]];
    end else if ((btn < BTN_LIMIT) && buttons_r[btn[2:0]]) begin
      tgt = 16'sd16384;
    end else begin
      tgt = 16'sd0;
    end
  end

  assign lvl         = started_item_r ? rd_data_r : 16'sd0;
  assign diff        = 17'(tgt) - 17'(lvl);
  assign smooth_prod = diff * $signed({1'b0, alpha_r});
  assign new_sum     = 17'(lvl) + smooth_prod[30:14];
  assign new_level   = new_sum[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r <= 1'b0;
    end else begin
      wr_en_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    wr_ch_r <= rd_ch;
    if (cmd.rd_en) begin
      rd_data_r <= level_mem[{hidx, rd_ch}];
    end
    if (wr_en_r) begin
      level_mem[{hidx, wr_ch_r}] <= new_level;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_r && (wr_ch_r < RES_LIMIT)) begin
      res_r[wr_ch_r[3:0]] <= new_level;
    end
  end

  // Output register; a rejected item shows all levels as zero.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted       <= cmd.out_accept;
      out_trigger_level  <= cmd.out_accept ? res_r[0][14:0]  : '0;
      out_grip_level     <= cmd.out_accept ? res_r[1][14:0]  : '0;
      out_stick_x_level  <= cmd.out_accept ? res_r[2]        : '0;
      out_stick_y_level  <= cmd.out_accept ? res_r[3]        : '0;
      out_button_level_0 <= cmd.out_accept ? res_r[4][14:0]  : '0;
      out_button_level_1 <= cmd.out_accept ? res_r[5][14:0]  : '0;
      out_button_level_2 <= cmd.out_accept ? res_r[6][14:0]  : '0;
      out_button_level_3 <= cmd.out_accept ? res_r[7][14:0]  : '0;
      out_button_level_4 <= cmd.out_accept ? res_r[8][14:0]  : '0;
      out_button_level_5 <= cmd.out_accept ? res_r[9][14:0]  : '0;
      out_button_level_6 <= cmd.out_accept ? res_r[10][14:0] : '0;
    end
  end

endmodule

/* design/controller_input_smoother.sv */
// Top level of the controller input smoother: state machine plus datapath.
// An accepted item goes through the alpha steps, one level memory read per channel and a drain
// step before the hand-over into the output register; a rejected item goes straight to the hand-over.
// Items are taken one at a time; the single read port of the level memory serves one channel per cycle.
// Reset (synchronous, active low) restores the configuration defaults and clears the started
// flags; the level memory is not cleared, as a hand's first item overwrites every level.
module controller_input_smoother #(
  parameter int BUTTON_COUNT = 7,
  parameter int HAND_COUNT   = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [csm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_hand,
  input  logic [19:0]                     in_elapsed_us,
  input  logic signed [15:0]              in_trigger_in,
  input  logic signed [15:0]              in_grip_in,
  input  logic signed [15:0]              in_stick_x_in,
  input  logic signed [15:0]              in_stick_y_in,
  input  logic [6:0]                      in_buttons_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [14:0]                     out_trigger_level,
  output logic [14:0]                     out_grip_level,
  output logic signed [15:0]              out_stick_x_level,
  output logic signed [15:0]              out_stick_y_level,
  output logic [14:0]                     out_button_level_0,
  output logic [14:0]                     out_button_level_1,
  output logic [14:0]                     out_button_level_2,
  output logic [14:0]                     out_button_level_3,
  output logic [14:0]                     out_button_level_4,
  output logic [14:0]                     out_button_level_5,
  output logic [14:0]                     out_button_level_6
);
  import csm_pkg::*;

  // Each hand owns CH level channels: trigger, grip, stick x, stick y, then
  // one per button. The level memory is addressed by {hand, channel}.
  localparam int CH  = ANALOG_PER_HAND + BUTTON_COUNT;
  localparam int CHW = $clog2(CH);
  localparam int HW  = (HAND_COUNT > 1) ? $clog2(HAND_COUNT) : 1;

  csm_cmd_t       cmd;
  csm_status_t    status;
  logic [CHW-1:0] rd_ch;

  // The state machine sequences one item at a time: capture, two alpha
  // steps on the shared multiplier, one channel per cycle through the level
  // memory, a drain step and a hand-over into the output register. The output
  // register frees the input side, so the next item is taken while the
  // previous result still waits for the consumer.
  csm_ctrl #(
    .CH  (CH),
    .CHW (CHW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .rd_ch     (rd_ch)
  );

  // The datapath holds the configuration registers, the started flags, the
  // item registers, the alpha arithmetic, the smoothing multiplier and the
  // level memory. A write to the presence register that changes a hand's bit
  // clears that hand's started flag, which makes its stored levels read as
  // zero until its next accepted item rewrites them.
  csm_dp #(
    .HAND_COUNT (HAND_COUNT),
    .CH         (CH),
    .CHW        (CHW),
    .HW         (HW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_hand            (in_hand),
    .in_elapsed_us      (in_elapsed_us),
    .in_trigger_in      (in_trigger_in),
    .in_grip_in         (in_grip_in),
    .in_stick_x_in      (in_stick_x_in),
    .in_stick_y_in      (in_stick_y_in),
    .in_buttons_in      (in_buttons_in),
    .cmd                (cmd),
    .rd_ch              (rd_ch),
    .status             (status),
    .out_accepted       (out_accepted),
    .out_trigger_level  (out_trigger_level),
    .out_grip_level     (out_grip_level),
    .out_stick_x_level  (out_stick_x_level),
    .out_stick_y_level  (out_stick_y_level),
    .out_button_level_0 (out_button_level_0),
    .out_button_level_1 (out_button_level_1),
    .out_button_level_2 (out_button_level_2),
    .out_button_level_3 (out_button_level_3),
    .out_button_level_4 (out_button_level_4),
    .out_button_level_5 (out_button_level_5),
    .out_button_level_6 (out_button_level_6)
  );

endmodule
